// ----- rtl/iirdf1_pkg.sv -----
package iirdf1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_BITS = 14;
  localparam int NTAPS     = 5;
  localparam int HIST_D    = NTAPS - 1;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_B3 = 3'd3,
    IDX_B4 = 3'd4,
    IDX_A1 = 3'd5
  } coef_idx_t;

  localparam sample_t RST_B0 = 16'sd32767;
  localparam sample_t RST_BN = 16'sd0;
  localparam sample_t RST_A1 = -16'sd16000;

  localparam acc_t SAT_MAX = acc_t'(32767);
  localparam acc_t SAT_MIN = -acc_t'(32768);

endpackage

// ----- rtl/iir_filter_direct_form_one_q14_top.sv -----
// Direct-form-I IIR filter in Q14 with one feedback tap.
// Input samples arrive as beats on the s_axis channel (16-bit signed sample in
// s_axis_tdata) and filtered samples leave as beats on the m_axis channel.
// Every input beat yields exactly one output beat, in order.
// Coefficients b0..b4 and a1 are written through cfg_we, cfg_addr and cfg_data
// (index 0..4 for b0..b4, index 5 for a1); other indexes are ignored. Write them
// only while no sample is in flight.
// An accepted input beat passes the tap register, product register,
// feed-forward sum register, and the output register before the output beat
// is valid. Throughput is one sample per cycle while the receiver does not
// stall; the cycle time is set by the feedback path, one 16x16 multiply, a
// subtract, and saturation, closing on the output register that holds y[n-1].
// A synchronous reset clears the input history and the previous output to zero,
// loads the default coefficients, and empties the pipeline.
// When the receiver stalls, each full stage keeps its beat and the stall
// reaches back only through full stages, so empty stages still take input beats.
module iir_filter_direct_form_one_q14_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  iirdf1_pkg::sample_t                    s_axis_tdata,   // [15:0] sample_in
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output iirdf1_pkg::sample_t                    m_axis_tdata,   // [15:0] sample_out
  input  logic                                   cfg_we,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  iirdf1_pkg::sample_t                    cfg_data
);
  import iirdf1_pkg::*;

  sample_t coef_b [NTAPS];
  sample_t coef_a1;
  sample_t taps [NTAPS];
  logic    tap_valid;
  logic    tap_ready;
  acc_t    ff_sum;
  logic    ff_valid;
  logic    ff_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b[0] <= RST_B0;
      for (int i = 1; i < NTAPS; i++) begin
        coef_b[i] <= RST_BN;
      end
      coef_a1 <= RST_A1;
    end else if (cfg_we) begin
      case (coef_idx_t'(cfg_addr))
        IDX_B0: coef_b[0] <= cfg_data;
        IDX_B1: coef_b[1] <= cfg_data;
        IDX_B2: coef_b[2] <= cfg_data;
        IDX_B3: coef_b[3] <= cfg_data;
        IDX_B4: coef_b[4] <= cfg_data;
        IDX_A1: coef_a1   <= cfg_data;
        default: ;
      endcase
    end
  end

  iirdf1_taps u_taps (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (s_axis_tdata),
    .out_valid (tap_valid),
    .out_ready (tap_ready),
    .taps      (taps)
  );

  iirdf1_ff u_ff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tap_valid),
    .in_ready  (tap_ready),
    .taps      (taps),
    .coef_b    (coef_b),
    .out_valid (ff_valid),
    .out_ready (ff_ready),
    .ff_sum    (ff_sum)
  );

  iirdf1_fb u_fb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ff_valid),
    .in_ready  (ff_ready),
    .ff_sum    (ff_sum),
    .coef_a1   (coef_a1),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .y         (m_axis_tdata)
  );

  a_out_follows_sum : assert property (@(posedge clk) disable iff (rst)
    ff_valid && ff_ready |=> m_axis_tvalid)
    else $error("Feed-forward sum was taken but no output beat followed.");

  a_y_holds : assert property (@(posedge clk) disable iff (rst)
    !(ff_valid && ff_ready) |=> $stable(m_axis_tdata))
    else $error("Previous output changed without a new result.");

  a_stall_needs_full : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> tap_valid && !tap_ready)
    else $error("Input stalled while the tap stage could take a beat.");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !ff_valid && !tap_valid)
    else $error("Pipeline not empty after reset.");

endmodule

// ----- rtl/iirdf1_taps.sv -----
module iirdf1_taps (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iirdf1_pkg::sample_t sample,
  output logic                out_valid,
  input  logic                out_ready,
  output iirdf1_pkg::sample_t taps [iirdf1_pkg::NTAPS]
);
  import iirdf1_pkg::*;

  sample_t hist [HIST_D];
  logic    load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < HIST_D; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        hist[0]   <= sample;
        for (int i = 1; i < HIST_D; i++) begin
          hist[i] <= hist[i-1];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      taps[0] <= sample;
      for (int i = 1; i < NTAPS; i++) begin
        taps[i] <= hist[i-1];
      end
    end
  end

endmodule

// ----- rtl/iirdf1_ff.sv -----
module iirdf1_ff (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iirdf1_pkg::sample_t taps   [iirdf1_pkg::NTAPS],
  input  iirdf1_pkg::sample_t coef_b [iirdf1_pkg::NTAPS],
  output logic                out_valid,
  input  logic                out_ready,
  output iirdf1_pkg::acc_t    ff_sum
);
  import iirdf1_pkg::*;

  prod_t prod [NTAPS];
  logic  prod_valid;
  logic  prod_ready;
  acc_t  sum_next;

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < NTAPS; i++) begin
        prod[i] <= prod_t'(taps[i] * coef_b[i]);
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NTAPS; i++) begin
      sum_next = sum_next + acc_t'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      ff_sum <= sum_next;
    end
  end

endmodule

// ----- rtl/iirdf1_fb.sv -----
module iirdf1_fb (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iirdf1_pkg::acc_t    ff_sum,
  input  iirdf1_pkg::sample_t coef_a1,
  output logic                out_valid,
  input  logic                out_ready,
  output iirdf1_pkg::sample_t y
);
  import iirdf1_pkg::*;

  prod_t   fb_prod;
  acc_t    acc;
  acc_t    shifted;
  sample_t y_next;

  assign in_ready = !out_valid || out_ready;

  // The output register also serves as y[n-1] for the feedback term.
  assign fb_prod = prod_t'(coef_a1 * y);
  assign acc     = ff_sum - acc_t'(fb_prod);
  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      y_next = sample_t'(SAT_MAX[SAMPLE_W-1:0]);
    end else if (shifted < SAT_MIN) begin
      y_next = sample_t'(SAT_MIN[SAMPLE_W-1:0]);
    end else begin
      y_next = sample_t'(shifted[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      y         <= '0;
    end else begin
      if (in_valid && in_ready) begin
        out_valid <= 1'b1;
        y         <= y_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import iirdf1_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_WAIT  = 8;
  localparam longint OUT_MAX     = 32767;
  localparam longint OUT_MIN     = -32768;
  localparam int     NUM_COEFS   = 6;

  // Indexes past the last coefficient; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

  localparam logic ROW_WRITE  = 1'b1;
  localparam logic ROW_SAMPLE = 1'b0;

  typedef struct packed {
    logic                 kind;
    logic [CFG_IDX_W-1:0] idx;
    sample_t              val;
    logic                 known;
    sample_t              want;
  } plan_row_t;

  localparam int PLAN_LEN = 42;

  plan_row_t plan [0:PLAN_LEN-1] = '{
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b1, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd32767,  1'b1, 16'sd32767},
    '{ROW_SAMPLE, IDX_B0, -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b1, -16'sd32000},
    '{ROW_SAMPLE, IDX_B0, 16'sd1234,   1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B0, 16'sd1,      1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_A1, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd1,     1'b1, -16'sd1},
    '{ROW_SAMPLE, IDX_B0, 16'sd1,      1'b1, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd16384,  1'b1, 16'sd1},
    '{ROW_SAMPLE, IDX_B0, -16'sd16385, 1'b1, -16'sd2},
    '{ROW_WRITE,  IDX_SPARE_6, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_SPARE_7, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd16384,  1'b1, 16'sd1},
    '{ROW_WRITE,  IDX_B0, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd32768, 1'b1, 16'sd32767},
    '{ROW_SAMPLE, IDX_B0, 16'sd32767,  1'b1, -16'sd32768},
    '{ROW_WRITE,  IDX_B1, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B2, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B3, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B4, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_A1, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd1,     1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B0, 16'sd16384,  1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B1, -16'sd8192,  1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B2, 16'sd4096,   1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B3, 16'sd0,      1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_B4, 16'sd1,      1'b0, 16'sd0},
    '{ROW_WRITE,  IDX_A1, -16'sd32768, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd100,    1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, -16'sd21846, 1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd21845,  1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0},
    '{ROW_SAMPLE, IDX_B0, 16'sd0,      1'b0, 16'sd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  sample_t              s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  sample_t              m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  sample_t              cfg_data = '0;

  sample_t coef [NUM_COEFS] = '{RST_B0, RST_BN, RST_BN, RST_BN, RST_BN, RST_A1};
  sample_t x_hist [HIST_D] = '{default: '0};
  sample_t y_prev = '0;

  sample_t pending_out [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      src_idle_pct = 0;
  int      sink_idle_pct = 0;

  iir_filter_direct_form_one_q14_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic sample_t filter_step(input sample_t x);
    longint acc;
    longint y;
    acc = longint'(x) * longint'(coef[IDX_B0]);
    for (int i = 0; i < HIST_D; i++) begin
      acc += longint'(x_hist[i]) * longint'(coef[i + 1]);
    end
    acc -= longint'(y_prev) * longint'(coef[IDX_A1]);
    y = acc >>> FRAC_BITS;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
    end
    for (int i = HIST_D - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i - 1];
    end
    x_hist[0] = x;
    y_prev = sample_t'(y);
    return y_prev;
  endfunction

  function automatic sample_t pick_coef();
    case ($urandom_range(5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return sample_t'($urandom_range(16384));
      4: return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_sample(input sample_t x, input logic known, input sample_t want);
    sample_t y;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk); while (!s_axis_tready);
    y = filter_step(x);
    pending_out.push_back(known ? want : y);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input sample_t val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_COEFS) begin
      coef[idx] = val;
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_out.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with nothing expected",
                                    m_axis_tdata));
        end else if (m_axis_tdata !== pending_out[0]) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    m_axis_tdata, pending_out[0]));
          void'(pending_out.pop_front());
        end else begin
          void'(pending_out.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("iir_filter_direct_form_one_q14_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 34;
    sink_idle_pct = 75;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        wait_drained();
        write_coef(plan[r].idx, plan[r].val);
      end else begin
        push_sample(plan[r].val, plan[r].known, plan[r].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 75 : 0;
      sink_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 34 : 0;
      for (int chunk = 0; chunk < 5; chunk++) begin
        wait_drained();
        write_coef(IDX_B0, pick_coef());
        write_coef(IDX_B1, pick_coef());
        write_coef(IDX_B2, pick_coef());
        write_coef(IDX_B3, pick_coef());
        write_coef(IDX_B4, pick_coef());
        write_coef(IDX_A1, pick_coef());
        for (int n = 0; n < 50; n++) begin
          push_sample(pick_sample(), 1'b0, '0);
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("iir_filter_direct_form_one_q14_top: match");
    end else begin
      $display("iir_filter_direct_form_one_q14_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/iirdf1_pkg.sv
rtl/iirdf1_taps.sv
rtl/iirdf1_ff.sv
rtl/iirdf1_fb.sv
rtl/iir_filter_direct_form_one_q14_top.sv
dv/testbench.sv
